// ===== src/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// sm3_pkg
// Types, constants and round functions shared by the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

   localparam logic [31:0] IV_WORDS [8] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};
   localparam logic [31:0] T_LOW    = 32'h79CC4519;
   localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
   } state_type;

   // fill source for the block buffer during padding
   typedef enum logic [1:0] {
      FILL_DATA, FILL_PAD, FILL_ZERO, FILL_LEN
   } fill_sel_type;

   typedef struct packed {
      logic         wr_en;      // write one byte to buffer
      logic [5:0]   wr_addr;
      fill_sel_type wr_sel;
      logic         load;       // latch block word into window, chain into regs
      logic [3:0]   load_idx;
      logic         rnd;        // run one round
      logic [5:0]   rnd_idx;
      logic         fold;       // xor work regs into chain value
      logic         reset_iv;   // return chain to IV
      logic         len_add;    // count one byte
      logic         len_clr;
   } cmd_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// ===== src/sm3_if.sv =====
// ----------------------------------------------------------------------------
// sm3_req_if / sm3_rsp_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sm3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       is_last;
   modport source (output valid, data_byte, byte_valid, is_last, input ready);
   modport sink   (input valid, data_byte, byte_valid, is_last, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== src/sm3_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sm3_hash_engine_unit
// SM3 hash: bytes in with a last mark, eight digest words out.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while a block fills. A full block is loaded
// into the message window, run through 64 rounds in the shared round
// datapath, then folded into the chain value. At the end of a message the pad
// sweep writes the remaining bytes of the block one per cycle, then one or two
// compressions run, then eight digest words leave one per accepted cycle.
module sm3_hash_engine_unit (
   input logic     clock,
   input logic     reset,
   sm3_req_if.sink   req,
   sm3_rsp_if.source rsp
);
   import sm3_pkg::*;

   cmd_type     cmd;
   logic [2:0]  out_idx;
   logic        rsp_valid;

   sm3_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp_ready(rsp.ready),
      .rsp_valid(rsp_valid), .out_idx(out_idx), .cmd(cmd)
   );

   sm3_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .data_byte(req.data_byte),
      .out_idx(out_idx), .out_word(rsp.digest_word)
   );

   assign rsp.valid      = rsp_valid;
   assign rsp.word_index = out_idx;
   assign rsp.last_word  = (out_idx == 3'd7);
endmodule

// ===== src/sm3_ram.sv =====
// ----------------------------------------------------------------------------
// sm3_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module sm3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/sm3_datapath.sv =====
// ----------------------------------------------------------------------------
// sm3_datapath
// Block buffer, length counter, message window, round registers, chain value.
// ----------------------------------------------------------------------------
module sm3_datapath (
   input  logic              clock,
   input  logic              reset,
   input  sm3_pkg::cmd_type  cmd,
   input  logic [7:0]        data_byte,
   input  logic [2:0]        out_idx,
   output logic [31:0]       out_word
);
   import sm3_pkg::*;

   logic [31:0] word_rd;
   logic [7:0]  wr_data;
   logic [63:0] bits_ff, bits_in;
   logic [31:0] chain_ff [8];
   logic [31:0] r_ff [8];
   logic [31:0] w_ff [16];
   logic [2:0]  len_byte;

   // buffer held as 16 words of 4 bytes; each byte lane is one RAM
   logic [7:0] lane_rd [4];
   genvar g;
   for (g = 0; g < 4; g++) begin : g_lane
      sm3_ram #(.WIDTH(8), .DEPTH(16)) u_ram (
         .clock  (clock),
         .wr_en  (cmd.wr_en && cmd.wr_addr[1:0] == 2'(g)),
         .wr_addr(cmd.wr_addr[5:2]),
         .wr_data(wr_data),
         .rd_addr(cmd.load_idx),
         .rd_data(lane_rd[g])
      );
   end
   assign word_rd = {lane_rd[0], lane_rd[1], lane_rd[2], lane_rd[3]};

   assign len_byte = 3'(7 - int'(cmd.wr_addr[2:0]));
   always_comb begin
      case (cmd.wr_sel)
         FILL_DATA: wr_data = data_byte;
         FILL_PAD:  wr_data = PAD_BYTE;
         FILL_ZERO: wr_data = 8'h00;
         FILL_LEN:  wr_data = bits_ff[{len_byte, 3'b000} +: 8];
         default:   wr_data = 8'h00;
      endcase
   end

   assign bits_in = cmd.len_clr ? 64'd0 : bits_ff + 64'd8;
   always_ff @(posedge clock) begin
      if (reset) bits_ff <= '0;
      else if (cmd.len_add || cmd.len_clr) bits_ff <= bits_in;
   end

   // round logic
   logic [3:0]  j0;
   logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, nw, tj, wj, wj4;
   assign j0  = cmd.rnd_idx[3:0];
   assign wj  = w_ff[j0];
   assign wj4 = w_ff[4'(j0 + 4'd4)];
   assign a12 = rotl(r_ff[0], 5'd12);
   assign tj  = rotl((cmd.rnd_idx < 6'd16) ? T_LOW : T_HIGH, cmd.rnd_idx[4:0]);
   assign ss1 = rotl(a12 + r_ff[4] + tj, 5'd7);
   assign ss2 = ss1 ^ a12;
   always_comb begin
      if (cmd.rnd_idx < 6'd16) begin
         ff = r_ff[0] ^ r_ff[1] ^ r_ff[2];
         gg = r_ff[4] ^ r_ff[5] ^ r_ff[6];
      end else begin
         ff = (r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]);
         gg = (r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]);
      end
   end
   assign tt1 = ff + r_ff[3] + ss2 + (wj ^ wj4);
   assign tt2 = gg + r_ff[7] + ss1 + wj;
   assign nw  = perm1(wj ^ w_ff[4'(j0 + 4'd7)] ^ rotl(w_ff[4'(j0 + 4'd13)], 5'd15))
              ^ rotl(w_ff[4'(j0 + 4'd3)], 5'd7) ^ w_ff[4'(j0 + 4'd10)];

   // window load writes the registered RAM read word in the cycle after the read
   logic       load_q_ff;
   logic [3:0] load_idx_q_ff;
   always_ff @(posedge clock) begin
      if (reset) load_q_ff <= 1'b0;
      else load_q_ff <= cmd.load;
      load_idx_q_ff <= cmd.load_idx;
   end

   always_ff @(posedge clock) begin
      if (load_q_ff) w_ff[load_idx_q_ff] <= word_rd;
      else if (cmd.rnd) w_ff[j0] <= nw;
      if (cmd.load) r_ff <= chain_ff;
      else if (cmd.rnd) begin
         r_ff[3] <= r_ff[2];
         r_ff[2] <= rotl(r_ff[1], 5'd9);
         r_ff[1] <= r_ff[0];
         r_ff[0] <= tt1;
         r_ff[7] <= r_ff[6];
         r_ff[6] <= rotl(r_ff[5], 5'd19);
         r_ff[5] <= r_ff[4];
         r_ff[4] <= perm0(tt2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reset_iv) chain_ff <= IV_WORDS;
      else if (cmd.fold)
         for (int k = 0; k < 8; k++) chain_ff[k] <= chain_ff[k] ^ r_ff[k];
   end

   assign out_word = chain_ff[out_idx];
endmodule

// ===== src/sm3_ctrl.sv =====
// ----------------------------------------------------------------------------
// sm3_ctrl
// Sequencer: byte intake, padding, block compression and digest output.
// ----------------------------------------------------------------------------
module sm3_ctrl (
   input  logic             clock,
   input  logic             reset,
   sm3_req_if.sink          req,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [2:0]       out_idx,
   output sm3_pkg::cmd_type cmd
);
   import sm3_pkg::*;

   state_type   state_ff, state_in;
   logic [6:0]  fill_ff, fill_in;     // next buffer write position
   logic        pad_ff, pad_in;       // padding in progress
   logic        padb_ff, padb_in;     // pad byte still to write
   logic        lenph_ff, lenph_in;   // final block gets length
   logic [4:0]  cnt_ff, cnt_in;       // load counter
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic        accept;

   assign accept  = req.valid && req.ready;
   assign out_idx = oidx_ff;
   assign rsp_valid = (state_ff == ST_EMIT);

   // next state
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      pad_in   = pad_ff;
      padb_in  = padb_ff;
      lenph_in = lenph_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      oidx_in  = oidx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pad_ff) begin
               // padding sweep: one byte a cycle up to end of block
               if (fill_ff == 7'd64) begin
                  state_in = ST_LOAD; cnt_in = '0;
               end else begin
                  fill_in = fill_ff + 7'd1;
                  padb_in = 1'b0;
               end
            end else if (accept) begin
               if (req.byte_valid) begin
                  fill_in = fill_ff + 7'd1;
                  if (req.is_last) begin
                     pad_in = 1'b1;
                     padb_in = 1'b1;
                     fill_in = fill_ff + 7'd1;
                     lenph_in = (fill_ff + 7'd1 <= 7'd55);
                  end else if (fill_ff == 7'd63) begin
                     state_in = ST_LOAD; cnt_in = '0;
                  end
               end else if (req.is_last) begin
                  pad_in = 1'b1;
                  padb_in = 1'b1;
                  lenph_in = (fill_ff <= 7'd55);
               end
            end
         end
         ST_LOAD: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               state_in = ST_ROUND; rnd_in = '0;
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            fill_in = '0;
            state_in = ST_IDLE;
            if (pad_ff) begin
               if (lenph_ff) begin
                  state_in = ST_EMIT; oidx_in = '0; pad_in = 1'b0;
               end else lenph_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.wr_sel   = FILL_DATA;
      cmd.wr_addr  = fill_ff[5:0];
      cmd.load_idx = cnt_ff[3:0];
      cmd.rnd_idx  = rnd_ff;
      req.ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pad_ff) begin
               cmd.wr_en = (fill_ff != 7'd64);
               if (padb_ff) cmd.wr_sel = FILL_PAD;
               else if (lenph_ff && fill_ff >= 7'd56) cmd.wr_sel = FILL_LEN;
               else cmd.wr_sel = FILL_ZERO;
            end else begin
               req.ready = 1'b1;
               if (accept) begin
                  cmd.wr_en   = 1'b1;
                  cmd.len_add = req.byte_valid;
                  if (req.byte_valid) cmd.wr_sel = FILL_DATA;
                  else cmd.wr_sel = FILL_PAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = (cnt_ff != 5'd16);
         end
         ST_ROUND: cmd.rnd  = 1'b1;
         ST_FOLD:  cmd.fold = 1'b1;
         ST_EMIT: begin
            if (rsp_ready && oidx_ff == 3'd7) begin
               cmd.reset_iv = 1'b1;
               cmd.len_clr  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; fill_ff <= '0; pad_ff <= 1'b0; lenph_ff <= 1'b0;
         cnt_ff <= '0; rnd_ff <= '0; oidx_ff <= '0; padb_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; pad_ff <= pad_in;
         lenph_ff <= lenph_in; cnt_ff <= cnt_in; rnd_ff <= rnd_in;
         oidx_ff <= oidx_in; padb_ff <= padb_in;
      end
   end

   property p_rsp_hold;
      @(posedge clock) disable iff (reset) rsp_valid && !rsp_ready |=> rsp_valid;
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp dropped");
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready) else $error("ready while busy");
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && rnd_ff == 6'd63 |=> state_ff == ST_FOLD)
      else $error("round count");
endmodule

// ===== verif/sm3_hash_engine_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_hash_engine_unit_checker
// Watches the message and digest channels of the SM3 engine, computes each
// digest from the accepted bytes and compares every digest word in order.
// ----------------------------------------------------------------------------
module sm3_hash_engine_unit_checker (
   input logic       clock,
   input logic       reset,
   sm3_req_if        req,
   sm3_rsp_if        rsp,
   output int        fail_count,
   output int        pending_words,
   output int        digest_count
);

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_item_type;

   digest_item_type digest_q[$];
   logic [31:0]  chain[8];
   logic [7:0]   msg_block[64];
   int unsigned  fill;
   logic [63:0]  msg_bits;

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] p0(input logic [31:0] x);
      return x ^ rol(x, 9) ^ rol(x, 17);
   endfunction

   function automatic logic [31:0] p1(input logic [31:0] x);
      return x ^ rol(x, 15) ^ rol(x, 23);
   endfunction

   task automatic compress();
      logic [31:0] w[68];
      logic [31:0] r[8];
      logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tc;
      for (int k = 0; k < 16; k++)
         w[k] = {msg_block[4*k], msg_block[4*k+1], msg_block[4*k+2], msg_block[4*k+3]};
      for (int k = 16; k < 68; k++)
         w[k] = p1(w[k-16] ^ w[k-9] ^ rol(w[k-3], 15)) ^ rol(w[k-13], 7) ^ w[k-6];
      for (int k = 0; k < 8; k++) r[k] = chain[k];
      for (int j = 0; j < 64; j++) begin
         a12 = rol(r[0], 12);
         tc  = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
         ss1 = rol(a12 + r[4] + rol(tc, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = r[0] ^ r[1] ^ r[2];
            gg = r[4] ^ r[5] ^ r[6];
         end else begin
            ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
            gg = (r[4] & r[5]) | (~r[4] & r[6]);
         end
         tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + r[7] + ss1 + w[j];
         r[3] = r[2]; r[2] = rol(r[1], 9); r[1] = r[0]; r[0] = tt1;
         r[7] = r[6]; r[6] = rol(r[5], 19); r[5] = r[4]; r[4] = p0(tt2);
      end
      for (int k = 0; k < 8; k++) chain[k] ^= r[k];
   endtask

   task automatic absorb_item(input logic [7:0] b, input logic bv, input logic last);
      digest_item_type e;
      if (bv) begin
         msg_block[fill] = b;
         msg_bits += 64'd8;
         fill++;
         if (fill == 64) begin
            compress();
            fill = 0;
         end
      end
      if (!last) return;
      msg_block[fill] = sm3_pkg::PAD_BYTE;
      for (int k = fill + 1; k < 64; k++) msg_block[k] = 8'h00;
      if (fill + 9 > 64) begin
         compress();
         for (int k = 0; k < 56; k++) msg_block[k] = 8'h00;
      end
      for (int k = 0; k < 8; k++) msg_block[56+k] = msg_bits[63-8*k -: 8];
      compress();
      for (int k = 0; k < 8; k++) begin
         e.digest_word = chain[k];
         e.word_index  = 3'(k);
         e.last_word   = (k == 7);
         digest_q.push_back(e);
      end
      for (int k = 0; k < 8; k++) chain[k] = sm3_pkg::IV_WORDS[k];
      fill     = 0;
      msg_bits = '0;
      digest_count++;
   endtask

   initial begin
      fail_count   = 0;
      digest_count = 0;
      fill         = 0;
      msg_bits     = '0;
      for (int k = 0; k < 8; k++) chain[k] = sm3_pkg::IV_WORDS[k];
   end

   assign pending_words = digest_q.size();

   always @(posedge clock) begin
      digest_item_type e;
      if (!reset) begin
         if (req.valid && req.ready)
            absorb_item(req.data_byte, req.byte_valid, req.is_last);
         if (rsp.valid && rsp.ready) begin
            if (digest_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected digest word %h idx %0d", rsp.digest_word,
                           rsp.word_index);
            end else begin
               e = digest_q.pop_front();
               if (rsp.digest_word !== e.digest_word || rsp.word_index !== e.word_index ||
                   rsp.last_word !== e.last_word) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                              e.digest_word, e.word_index, e.last_word,
                              rsp.digest_word, rsp.word_index, rsp.last_word);
               end
            end
         end
      end
   end

endmodule

// ===== verif/sm3_hash_engine_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_hash_engine_unit_test
// Drives messages of many lengths (empty, one byte, block edges, two-block
// padding, idle items) with random gaps and stalls; a checker compares digests.
// ----------------------------------------------------------------------------
module sm3_hash_engine_unit_test;

   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   int   fail_count, pending_words, digest_count;
   int   idle_cycles;
   int   items_sent;
   bit   stalls_on;

   sm3_req_if req ();
   sm3_rsp_if rsp ();

   sm3_hash_engine_unit dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   sm3_hash_engine_unit_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .pending_words(pending_words),
      .digest_count(digest_count));

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
      return $urandom_range(3, 40);
   endfunction

   task automatic send_item(input logic [7:0] b, input logic bv, input logic last);
      int g;
      g = stalls_on ? gap_len() : 0;
      repeat (g) @(negedge clock);
      req.valid      <= 1'b1;
      req.data_byte  <= b;
      req.byte_valid <= bv;
      req.is_last    <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
      req.valid      <= 1'b0;
      req.data_byte  <= 8'($urandom);
   endtask

   // send a message of len bytes, optionally with idle items and a byteless end
   task automatic send_message(input int len, input bit noisy, input bit byteless_end);
      for (int k = 0; k < len; k++) begin
         if (noisy && $urandom_range(0, 7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, (k == len - 1) && !byteless_end);
      end
      if (byteless_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // rsp ready, with random stalls while stalls_on is set
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (!stalls_on) rsp.ready <= 1'b1;
      else if ($urandom_range(0, 9) < 6) rsp.ready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(0, 2) == 0);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int lens[$];
      idle_cycles    = 0;
      items_sent     = 0;
      stalls_on      = 1'b0;
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.data_byte  = 8'h00;
      req.byte_valid = 1'b0;
      req.is_last    = 1'b0;
      rsp.ready      = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hAA, 1'b0, 1'b0);
      send_item(8'h55, 1'b1, 1'b0);
      send_item(8'h80, 1'b0, 1'b1);
      stalls_on = 1'b1;
      lens = '{55, 56, 64, 0, 1, 5};
      foreach (lens[i]) send_message(lens[i], 1'b1, $urandom_range(0, 3) == 0);
      while (items_sent < 200)
         send_message($urandom_range(0, 20), 1'b1, $urandom_range(0, 4) == 0);
      stalls_on = 1'b0;
      while (pending_words != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Sent %0d items in %0d messages, incl. empty, block-edge and two-block pads.",
               items_sent, digest_count);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
